@@ src/mlfq_pkg.sv @@
// Shared constants, types and helper functions of the task scheduler.
`timescale 1ns / 1ps

package mlfq_pkg;

    localparam int TASK_SLOTS   = 64;
    localparam int LEVEL_COUNT  = 5;

    localparam int SLOT_W       = $clog2(TASK_SLOTS);
    localparam int CNT_W        = $clog2(TASK_SLOTS + 1);
    localparam int LVL_W        = $clog2(LEVEL_COUNT);
    localparam int LVLC_W       = $clog2(LEVEL_COUNT + 1);
    localparam int RADDR_W      = $clog2(LEVEL_COUNT * TASK_SLOTS);
    localparam int OP_W         = 3;
    localparam int ID_W         = 6;
    localparam int RSTAT_W      = 2;
    localparam int BASE_W       = 10;
    localparam int SLICE_W      = 16;
    localparam int PROD_W       = LVLC_W + BASE_W;

    localparam int BASE_RESET   = 10;
    localparam int IDLE_SLICE   = 100;
    localparam int CREATE_LEVEL = (2 < LEVEL_COUNT) ? 2 : LEVEL_COUNT - 1;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 3'd0,
        OP_TICK    = 3'd1,
        OP_PICK    = 3'd2,
        OP_BLOCK   = 3'd3,
        OP_WAKE    = 3'd4,
        OP_BOOST   = 3'd5,
        OP_KILL    = 3'd6,
        OP_REQUEUE = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        TS_RUNNING = 2'd0,
        TS_READY   = 2'd1,
        TS_BLOCKED = 2'd2,
        TS_ZOMBIE  = 2'd3
    } t_tstat;

    typedef enum logic [RSTAT_W-1:0] {
        RS_DONE    = 2'd0,
        RS_IGNORED = 2'd1,
        RS_FULL    = 2'd2
    } t_rstat;

    typedef struct packed {
        t_tstat             st;
        logic [LVL_W-1:0]   lvl;
        logic [LVL_W-1:0]   home;
        logic [SLICE_W-1:0] slice;
    } t_task;

    localparam t_task IDLE_ENTRY = '{
        st:    TS_READY,
        lvl:   LVL_W'(LEVEL_COUNT - 1),
        home:  LVL_W'(LEVEL_COUNT - 1),
        slice: SLICE_W'(IDLE_SLICE)
    };

    typedef enum logic [2:0] {
        SS_KEEP, SS_ID, SS_NEW, SS_RUN, SS_POP, SS_ZERO
    } t_slot_sel;

    typedef enum logic [2:0] {
        LS_KEEP, LS_ZERO, LS_CREATE, LS_TASK, LS_HOME, LS_NEXT
    } t_lvl_sel;

    typedef enum logic [3:0] {
        ED_NONE, ED_CREATE, ED_TICK, ED_DEMOTE, ED_RUN, ED_REFILL,
        ED_BLOCK, ED_WAKE, ED_BOOST, ED_KILL, ED_READY
    } t_edit;

    typedef enum logic [3:0] {
        RO_NONE, RO_PUSH, RO_POP, RO_SCAN_INIT, RO_SCAN_RD, RO_SCAN_NEXT,
        RO_SHIFT_RD, RO_SHIFT_WR, RO_REMOVE
    } t_ring_op;

    typedef enum logic [2:0] {
        RES_HOLD, RES_IGNORED, RES_DONE, RES_SLOT, RES_FULL
    } t_res;

    typedef struct packed {
        logic      load_in;
        t_slot_sel slot_sel;
        t_lvl_sel  lvl_sel;
        logic      calc;
        t_edit     edit;
        logic      t_rd;
        logic      t_latch;
        logic      t_wr;
        logic      slots_inc;
        t_ring_op  ring;
        logic      run_set;
        logic      run_clr;
        t_res      res;
    } t_dp_cmd;

    typedef struct packed {
        logic   full;
        logic   id_valid;
        logic   run_valid;
        t_tstat tst;
        logic   slice_zero;
        logic   ring_empty;
        logic   lvl_last;
        logic   match;
        logic   scan_end;
        logic   shift_end;
        logic   out_free;
    } t_dp_stat;

    function automatic logic [LVL_W-1:0] lvl_fix(input logic [LVL_W-1:0] lvl);
        return (32'(lvl) < LEVEL_COUNT) ? lvl : LVL_W'(LEVEL_COUNT - 1);
    endfunction

    // Ring index a + b modulo the ring size; a is below it and b at most it.
    function automatic logic [SLOT_W-1:0] wrap_add(input logic [SLOT_W-1:0] a,
                                                   input logic [CNT_W-1:0]  b);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
        if (s >= (CNT_W + 1)'(TASK_SLOTS)) s = s - (CNT_W + 1)'(TASK_SLOTS);
        return SLOT_W'(s);
    endfunction

    function automatic logic [RADDR_W-1:0] ring_addr(input logic [LVL_W-1:0]  lvl,
                                                     input logic [SLOT_W-1:0] idx);
        return RADDR_W'(lvl) * RADDR_W'(TASK_SLOTS) + RADDR_W'(idx);
    endfunction

endpackage

@@ src/mlfq_if.sv @@
// Handshake channel interfaces: task operations, results and configuration.
`timescale 1ns / 1ps

interface mlfq_task_if;
    logic                      valid;
    logic                      ready;
    logic [mlfq_pkg::OP_W-1:0] op;
    logic [mlfq_pkg::ID_W-1:0] task_id;
    modport source (output valid, output op, output task_id, input ready);
    modport sink   (input valid, input op, input task_id, output ready);
endinterface

interface mlfq_result_if;
    logic                         valid;
    logic                         ready;
    logic [mlfq_pkg::ID_W-1:0]    chosen_task;
    logic [mlfq_pkg::RSTAT_W-1:0] status;
    modport source (output valid, output chosen_task, output status, input ready);
    modport sink   (input valid, input chosen_task, input status, output ready);
endinterface

interface mlfq_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mlfq_pkg::BASE_W-1:0] slice_base;
    modport source (output valid, output slice_base, input ready);
    modport sink   (input valid, input slice_base, output ready);
endinterface

@@ src/mlfq_dpath.sv @@
// Scheduler datapath: task table, level rings, ring pointers and result register.
`timescale 1ns / 1ps

module mlfq_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mlfq_pkg::t_dp_cmd            i_cmd,
    output mlfq_pkg::t_dp_stat           o_stat,
    input  logic [mlfq_pkg::ID_W-1:0]    i_task_id,
    input  logic                         i_cfg_valid,
    input  logic [mlfq_pkg::BASE_W-1:0]  i_cfg_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [mlfq_pkg::ID_W-1:0]    o_chosen_task,
    output logic [mlfq_pkg::RSTAT_W-1:0] o_status
);
    import mlfq_pkg::*;

    t_task              m_task [TASK_SLOTS];
    logic [SLOT_W-1:0]  m_ring [LEVEL_COUNT * TASK_SLOTS];

    logic [BASE_W-1:0]  r_slice_base;
    logic [ID_W-1:0]    r_id;
    logic [SLOT_W-1:0]  r_slot;
    logic [LVL_W-1:0]   r_lvl;
    t_task              r_task;
    t_task              r_tq;
    logic [SLICE_W-1:0] r_fresh;
    logic [SLOT_W-1:0]  r_rdata;
    logic [SLOT_W-1:0]  r_head [LEVEL_COUNT];
    logic [SLOT_W-1:0]  r_tail [LEVEL_COUNT];
    logic [CNT_W-1:0]   r_count [LEVEL_COUNT];
    logic [CNT_W-1:0]   r_i;
    logic [CNT_W-1:0]   r_n;
    logic               r_run_valid;
    logic [SLOT_W-1:0]  r_run_slot;
    logic [CNT_W-1:0]   r_slots_used;
    logic               r_s0_written;
    logic               r_out_valid;
    logic [ID_W-1:0]    r_chosen;
    t_rstat             r_status;

    logic [SLOT_W-1:0]  w_head;
    logic [SLOT_W-1:0]  w_tail;
    logic [CNT_W-1:0]   w_count;
    logic               w_ring_full;
    logic [LVLC_W-1:0]  w_units;
    logic [PROD_W-1:0]  w_prod;
    t_task              w_edit;
    logic [RADDR_W-1:0] w_raddr;
    logic               w_ring_we;
    logic               w_ring_re;
    logic [SLOT_W-1:0]  w_ring_wdata;

    assign w_head      = r_head[r_lvl];
    assign w_tail      = r_tail[r_lvl];
    assign w_count     = r_count[r_lvl];
    assign w_ring_full = (w_count >= CNT_W'(TASK_SLOTS));
    assign w_units     = LVLC_W'(LEVEL_COUNT) - LVLC_W'(lvl_fix(r_lvl));
    assign w_prod      = PROD_W'(w_units) * PROD_W'(r_slice_base);

    always_comb begin
        w_edit = r_task;
        case (i_cmd.edit)
            ED_CREATE: begin
                w_edit.st    = TS_READY;
                w_edit.lvl   = r_lvl;
                w_edit.home  = r_lvl;
                w_edit.slice = r_fresh;
            end
            ED_TICK: begin
                if (r_task.slice != '0) w_edit.slice = r_task.slice - SLICE_W'(1);
            end
            ED_DEMOTE: begin
                w_edit.st = TS_READY;
                if (32'(r_task.lvl) + 1 < LEVEL_COUNT) w_edit.lvl = r_task.lvl + LVL_W'(1);
            end
            ED_RUN:    w_edit.st = TS_RUNNING;
            ED_REFILL: begin
                if (r_task.slice == '0) w_edit.slice = r_fresh;
            end
            ED_BLOCK:  w_edit.st = TS_BLOCKED;
            ED_WAKE: begin
                w_edit.st    = TS_READY;
                w_edit.lvl   = r_lvl;
                w_edit.slice = r_fresh;
            end
            ED_BOOST: begin
                w_edit.st    = TS_READY;
                w_edit.home  = r_task.lvl;
                w_edit.lvl   = '0;
                w_edit.slice = r_fresh;
            end
            ED_KILL:   w_edit.st = TS_ZOMBIE;
            ED_READY:  w_edit.st = TS_READY;
            default:   w_edit = r_task;
        endcase
    end

    always_comb begin
        w_raddr      = ring_addr(r_lvl, w_head);
        w_ring_we    = 1'b0;
        w_ring_re    = 1'b0;
        w_ring_wdata = r_rdata;
        case (i_cmd.ring)
            RO_PUSH: begin
                w_raddr      = ring_addr(r_lvl, w_tail);
                w_ring_we    = !w_ring_full;
                w_ring_wdata = r_slot;
            end
            RO_POP: w_ring_re = 1'b1;
            RO_SCAN_RD: begin
                w_raddr   = ring_addr(r_lvl, wrap_add(w_head, r_i));
                w_ring_re = 1'b1;
            end
            RO_SHIFT_RD: begin
                w_raddr   = ring_addr(r_lvl, wrap_add(w_head, r_i + CNT_W'(1)));
                w_ring_re = 1'b1;
            end
            RO_SHIFT_WR: begin
                w_raddr   = ring_addr(r_lvl, wrap_add(w_head, r_i));
                w_ring_we = 1'b1;
            end
            default: w_ring_we = 1'b0;
        endcase
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        if (w_ring_we) m_ring[w_raddr] <= w_ring_wdata;
        if (w_ring_re) r_rdata <= m_ring[w_raddr];
        if (i_cmd.t_wr) m_task[r_slot] <= w_edit;
        if (i_cmd.t_rd) r_tq <= m_task[r_slot];
    end

    // Working payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) r_id <= i_task_id;
        case (i_cmd.slot_sel)
            SS_ID:   r_slot <= SLOT_W'(r_id);
            SS_NEW:  r_slot <= SLOT_W'(r_slots_used);
            SS_RUN:  r_slot <= r_run_slot;
            SS_POP:  r_slot <= r_rdata;
            SS_ZERO: r_slot <= '0;
            default: r_slot <= r_slot;
        endcase
        case (i_cmd.lvl_sel)
            LS_ZERO:   r_lvl <= '0;
            LS_CREATE: r_lvl <= LVL_W'(CREATE_LEVEL);
            LS_TASK:   r_lvl <= lvl_fix(r_task.lvl);
            LS_HOME:   r_lvl <= lvl_fix(r_task.home);
            LS_NEXT:   r_lvl <= r_lvl + LVL_W'(1);
            default:   r_lvl <= r_lvl;
        endcase
        if (i_cmd.calc) r_fresh <= SLICE_W'(w_prod);
        if (i_cmd.t_latch) begin
            // The idle task keeps its reset entry until first written back.
            r_task <= (r_slot == '0 && !r_s0_written) ? IDLE_ENTRY : r_tq;
        end else if (i_cmd.edit != ED_NONE) begin
            r_task <= w_edit;
        end
        case (i_cmd.ring)
            RO_SCAN_INIT: begin
                r_i <= '0;
                r_n <= w_count;
            end
            RO_SCAN_NEXT, RO_SHIFT_WR: r_i <= r_i + CNT_W'(1);
            default: r_i <= r_i;
        endcase
        case (i_cmd.res)
            RES_IGNORED: begin
                r_chosen <= '0;
                r_status <= RS_IGNORED;
            end
            RES_DONE: begin
                r_chosen <= '0;
                r_status <= RS_DONE;
            end
            RES_SLOT: begin
                r_chosen <= ID_W'(r_slot);
                r_status <= RS_DONE;
            end
            RES_FULL: begin
                r_chosen <= '0;
                r_status <= RS_FULL;
            end
            default: r_chosen <= r_chosen;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_base <= BASE_W'(BASE_RESET);
            for (int k = 0; k < LEVEL_COUNT; k++) begin
                r_head[k]  <= '0;
                r_tail[k]  <= '0;
                r_count[k] <= '0;
            end
            r_run_valid  <= 1'b0;
            r_run_slot   <= '0;
            r_slots_used <= CNT_W'(1);
            r_s0_written <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) r_slice_base <= i_cfg_data;
            case (i_cmd.ring)
                RO_PUSH: begin
                    if (!w_ring_full) begin
                        r_tail[r_lvl]  <= wrap_add(w_tail, CNT_W'(1));
                        r_count[r_lvl] <= w_count + CNT_W'(1);
                    end
                end
                RO_POP: begin
                    r_head[r_lvl]  <= wrap_add(w_head, CNT_W'(1));
                    r_count[r_lvl] <= w_count - CNT_W'(1);
                end
                RO_REMOVE: begin
                    r_tail[r_lvl]  <= (w_tail == '0) ? SLOT_W'(TASK_SLOTS - 1)
                                                     : w_tail - SLOT_W'(1);
                    r_count[r_lvl] <= w_count - CNT_W'(1);
                end
                default: r_count[r_lvl] <= w_count;
            endcase
            if (i_cmd.run_set) begin
                r_run_valid <= 1'b1;
                r_run_slot  <= r_slot;
            end else if (i_cmd.run_clr && r_run_valid && r_run_slot == r_slot) begin
                r_run_valid <= 1'b0;
            end
            if (i_cmd.slots_inc) r_slots_used <= r_slots_used + CNT_W'(1);
            if (i_cmd.t_wr && r_slot == '0) r_s0_written <= 1'b1;
            if (i_cmd.res != RES_HOLD) r_out_valid <= 1'b1;
            else if (i_out_ready)      r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.full       = (r_slots_used >= CNT_W'(TASK_SLOTS));
        o_stat.id_valid   = (32'(r_id) < 32'(r_slots_used)) && (32'(r_id) < TASK_SLOTS);
        o_stat.run_valid  = r_run_valid;
        o_stat.tst        = r_task.st;
        o_stat.slice_zero = (r_task.slice == '0);
        o_stat.ring_empty = (w_count == '0);
        o_stat.lvl_last   = (r_lvl == LVL_W'(LEVEL_COUNT - 1));
        o_stat.match      = (r_rdata == r_slot);
        o_stat.scan_end   = (r_i >= r_n);
        o_stat.shift_end  = ((CNT_W + 1)'(r_i) + (CNT_W + 1)'(1) >= (CNT_W + 1)'(r_n));
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_chosen_task = r_chosen;
    assign o_status      = r_status;

    a_slots_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slots_used != '0 && r_slots_used <= CNT_W'(TASK_SLOTS))
        else $error("slots_used out of range");
    a_run_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> 32'(r_run_slot) < 32'(r_slots_used))
        else $error("running slot not in use");
    a_res_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res != RES_HOLD |=> r_out_valid)
        else $error("result loaded without valid");

endmodule

@@ src/mlfq_ctrl.sv @@
// Scheduler controller: sequences each operation over the datapath.
`timescale 1ns / 1ps

module mlfq_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [mlfq_pkg::OP_W-1:0] i_op,
    output logic                      o_ready,
    input  mlfq_pkg::t_dp_stat        i_stat,
    output mlfq_pkg::t_dp_cmd         o_cmd
);
    import mlfq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_RD, S_LAT, S_EXEC, S_CALC, S_CR_WR, S_PK_CHK, S_PK_POP,
        S_PK_WR, S_WK_WR, S_BO_E, S_BO_LVL, S_TK_END, S_TK_DW, S_PUSH,
        S_RM_INIT, S_RM_TEST, S_RM_CMP, S_RM_SH, S_RM_SW, S_FIN
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    t_res   r_res, n_res;
    logic   r_idle, n_idle;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_res   = r_res;
        n_idle  = r_idle;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_op          = t_op'(i_op);
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                unique case (r_op)
                    OP_CREATE: begin
                        if (i_stat.full) begin
                            n_res   = RES_FULL;
                            n_state = S_FIN;
                        end else begin
                            o_cmd.slot_sel = SS_NEW;
                            o_cmd.lvl_sel  = LS_CREATE;
                            n_state        = S_CALC;
                        end
                    end
                    OP_TICK: begin
                        if (!i_stat.run_valid) begin
                            n_res   = RES_IGNORED;
                            n_state = S_FIN;
                        end else begin
                            o_cmd.slot_sel = SS_RUN;
                            n_state        = S_RD;
                        end
                    end
                    OP_PICK: begin
                        n_idle        = 1'b0;
                        o_cmd.lvl_sel = LS_ZERO;
                        n_state       = S_PK_CHK;
                    end
                    default: begin
                        if (!i_stat.id_valid) begin
                            n_res   = RES_IGNORED;
                            n_state = S_FIN;
                        end else begin
                            o_cmd.slot_sel = SS_ID;
                            n_state        = S_RD;
                        end
                    end
                endcase
            end
            S_RD: begin
                o_cmd.t_rd = 1'b1;
                n_state    = S_LAT;
            end
            S_LAT: begin
                o_cmd.t_latch = 1'b1;
                n_state       = S_EXEC;
            end
            S_EXEC: begin
                n_res   = RES_IGNORED;
                n_state = S_FIN;
                unique case (r_op)
                    OP_TICK: begin
                        if (i_stat.tst == TS_RUNNING) begin
                            o_cmd.edit = ED_TICK;
                            n_state    = S_TK_END;
                        end
                    end
                    OP_PICK: begin
                        if (i_stat.tst == TS_READY) begin
                            o_cmd.edit    = ED_RUN;
                            o_cmd.run_set = 1'b1;
                            if (r_idle) begin
                                o_cmd.t_wr = 1'b1;
                                n_res      = RES_SLOT;
                            end else begin
                                o_cmd.lvl_sel = LS_TASK;
                                n_state       = S_CALC;
                            end
                        end else if (!r_idle) begin
                            if (i_stat.lvl_last) begin
                                o_cmd.slot_sel = SS_ZERO;
                                n_idle         = 1'b1;
                                n_state        = S_RD;
                            end else begin
                                o_cmd.lvl_sel = LS_NEXT;
                                n_state       = S_PK_CHK;
                            end
                        end
                    end
                    OP_BLOCK: begin
                        o_cmd.edit    = ED_BLOCK;
                        o_cmd.t_wr    = 1'b1;
                        o_cmd.lvl_sel = LS_TASK;
                        o_cmd.run_clr = 1'b1;
                        n_state       = S_RM_INIT;
                    end
                    OP_WAKE: begin
                        if (i_stat.tst == TS_BLOCKED) begin
                            o_cmd.lvl_sel = LS_HOME;
                            n_state       = S_CALC;
                        end
                    end
                    OP_BOOST: begin
                        o_cmd.lvl_sel = LS_ZERO;
                        n_state       = S_CALC;
                    end
                    OP_KILL: begin
                        if (i_stat.tst != TS_ZOMBIE) begin
                            o_cmd.edit    = ED_KILL;
                            o_cmd.t_wr    = 1'b1;
                            o_cmd.lvl_sel = LS_TASK;
                            o_cmd.run_clr = 1'b1;
                            n_state       = S_RM_INIT;
                        end
                    end
                    OP_REQUEUE: begin
                        if (i_stat.tst == TS_RUNNING) begin
                            o_cmd.edit    = ED_READY;
                            o_cmd.t_wr    = 1'b1;
                            o_cmd.lvl_sel = LS_TASK;
                            o_cmd.run_clr = 1'b1;
                            n_state       = S_PUSH;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                unique case (r_op)
                    OP_CREATE: n_state = S_CR_WR;
                    OP_PICK:   n_state = S_PK_WR;
                    OP_WAKE:   n_state = S_WK_WR;
                    OP_BOOST:  n_state = S_BO_E;
                    default: begin
                        n_res   = RES_IGNORED;
                        n_state = S_FIN;
                    end
                endcase
            end
            S_CR_WR: begin
                o_cmd.edit      = ED_CREATE;
                o_cmd.t_wr      = 1'b1;
                o_cmd.slots_inc = 1'b1;
                o_cmd.ring      = RO_PUSH;
                n_res           = RES_SLOT;
                n_state         = S_FIN;
            end
            S_PK_CHK: begin
                if (i_stat.ring_empty) begin
                    if (i_stat.lvl_last) begin
                        o_cmd.slot_sel = SS_ZERO;
                        n_idle         = 1'b1;
                        n_state        = S_RD;
                    end else begin
                        o_cmd.lvl_sel = LS_NEXT;
                    end
                end else begin
                    o_cmd.ring = RO_POP;
                    n_state    = S_PK_POP;
                end
            end
            S_PK_POP: begin
                o_cmd.slot_sel = SS_POP;
                n_state        = S_RD;
            end
            S_PK_WR: begin
                o_cmd.edit = ED_REFILL;
                o_cmd.t_wr = 1'b1;
                n_res      = RES_SLOT;
                n_state    = S_FIN;
            end
            S_WK_WR: begin
                o_cmd.edit = ED_WAKE;
                o_cmd.t_wr = 1'b1;
                o_cmd.ring = RO_PUSH;
                n_res      = RES_DONE;
                n_state    = S_FIN;
            end
            S_BO_E: begin
                o_cmd.edit    = ED_BOOST;
                o_cmd.t_wr    = 1'b1;
                o_cmd.lvl_sel = LS_TASK;
                n_state       = S_RM_INIT;
            end
            S_BO_LVL: begin
                o_cmd.lvl_sel = LS_ZERO;
                n_state       = S_PUSH;
            end
            S_TK_END: begin
                if (i_stat.slice_zero) begin
                    o_cmd.edit = ED_DEMOTE;
                    n_state    = S_TK_DW;
                end else begin
                    o_cmd.t_wr = 1'b1;
                    n_res      = RES_DONE;
                    n_state    = S_FIN;
                end
            end
            S_TK_DW: begin
                o_cmd.t_wr    = 1'b1;
                o_cmd.lvl_sel = LS_TASK;
                o_cmd.run_clr = 1'b1;
                n_state       = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.ring = RO_PUSH;
                n_res      = RES_DONE;
                n_state    = S_FIN;
            end
            S_RM_INIT: begin
                o_cmd.ring = RO_SCAN_INIT;
                n_state    = S_RM_TEST;
            end
            S_RM_TEST: begin
                if (i_stat.scan_end) begin
                    if (r_op == OP_BOOST) begin
                        n_state = S_BO_LVL;
                    end else begin
                        n_res   = RES_DONE;
                        n_state = S_FIN;
                    end
                end else begin
                    o_cmd.ring = RO_SCAN_RD;
                    n_state    = S_RM_CMP;
                end
            end
            S_RM_CMP: begin
                if (i_stat.match) begin
                    n_state = S_RM_SH;
                end else begin
                    o_cmd.ring = RO_SCAN_NEXT;
                    n_state    = S_RM_TEST;
                end
            end
            S_RM_SH: begin
                if (i_stat.shift_end) begin
                    o_cmd.ring = RO_REMOVE;
                    if (r_op == OP_BOOST) begin
                        n_state = S_BO_LVL;
                    end else begin
                        n_res   = RES_DONE;
                        n_state = S_FIN;
                    end
                end else begin
                    o_cmd.ring = RO_SHIFT_RD;
                    n_state    = S_RM_SW;
                end
            end
            S_RM_SW: begin
                o_cmd.ring = RO_SHIFT_WR;
                n_state    = S_RM_SH;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.res = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_CREATE;
            r_res   <= RES_HOLD;
            r_idle  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_res   <= n_res;
            r_idle  <= n_idle;
        end
    end

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_state == S_DEC)
        else $error("accepted transaction not decoded");
    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && !i_stat.out_free |=> r_state == S_FIN)
        else $error("result dropped while output stalled");

endmodule

@@ src/mlfq_task_scheduler_top.sv @@
// Top level of the multilevel feedback queue task scheduler.
`timescale 1ns / 1ps
//
// Usage:
// i_task carries one operation per transaction (op, task_id). Each accepted
// transaction produces exactly one transaction on o_result (chosen_task,
// status), in order. i_cfg writes the slice_base register; it is always
// ready and should only be written while the scheduler is idle.
// Sequencing: an operation rejected at decode (full table, no running task or
// an invalid id) goes straight to its final state. The ring removal done by
// block, kill and boost grows with N, the ring length of one level: the scan
// reads and compares one ring entry at a time, and the shift reads and then
// writes each entry through the single-port ring memory. Pick next steps over
// each empty level and pops the head entry of each nonempty level until it
// finds a ready task; a tick adds a demote and a push when the slice runs out.
// One operation is in flight at a time, but the next transaction is accepted
// while the previous result still waits in the output register.
// Reset: synchronous, active low. It empties all rings, marks only slot 0 in
// use, holding the ready idle task, and needs no clearing pass.
// When the receiver stalls o_result, the finished operation waits in its
// final state until the result register frees up.

module mlfq_task_scheduler_top (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mlfq_task_if.sink     i_task,
    mlfq_result_if.source o_result,
    mlfq_cfg_if.sink      i_cfg
);
    import mlfq_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_ready;

    // The controller owns the operation sequencing and the input handshake.
    mlfq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_task.valid),
        .i_op    (i_task.op),
        .o_ready (w_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // The datapath holds all scheduler state and the result register.
    mlfq_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_task_id     (i_task.task_id),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_data    (i_cfg.slice_base),
        .o_out_valid   (o_result.valid),
        .i_out_ready   (o_result.ready),
        .o_chosen_task (o_result.chosen_task),
        .o_status      (o_result.status)
    );

    assign i_task.ready = w_ready;
    assign i_cfg.ready  = 1'b1;

endmodule

@@ verif/mlfq_task_scheduler_top_tb.sv @@
// Self-checking testbench of the multilevel feedback queue task scheduler.
`timescale 1ns / 1ps

module mlfq_task_scheduler_top_tb;
    import mlfq_pkg::*;

    typedef struct {
        t_op             op;
        logic [ID_W-1:0] task_id;
        bit              is_cfg;
        logic [BASE_W-1:0] base;
    } t_item;

    typedef struct {
        logic [ID_W-1:0] chosen;
        t_rstat          status;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    mlfq_task_if   task_ch ();
    mlfq_result_if result_ch ();
    mlfq_cfg_if    cfg_ch ();

    mlfq_task_scheduler_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_task   (task_ch.sink),
        .o_result (result_ch.source),
        .i_cfg    (cfg_ch.sink)
    );

    // Shadow copy of the scheduler state, updated as each transaction is accepted.
    logic [ID_W-1:0]    ring_slot [LEVEL_COUNT][TASK_SLOTS];
    int                 ring_head [LEVEL_COUNT];
    int                 ring_tail [LEVEL_COUNT];
    int                 ring_len  [LEVEL_COUNT];
    t_tstat             slot_state [TASK_SLOTS];
    int                 slot_lvl   [TASK_SLOTS];
    int                 slot_home  [TASK_SLOTS];
    logic [SLICE_W-1:0] slot_slice [TASK_SLOTS];
    bit                 run_valid;
    int                 run_slot;
    int                 used_slots;
    logic [BASE_W-1:0]  base_reg;

    t_item    pending_ops [$];
    t_outcome expected_results [$];

    int  mismatches;
    int  results_seen;
    int  cfg_writes;
    bit  phase_fence;
    bit  task_taken;
    int  burst_left;
    int  gap_left;
    int  stall_cnt;
    bit  stall_mode;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int fix_lvl(input int lvl);
        return (lvl < LEVEL_COUNT) ? lvl : LEVEL_COUNT - 1;
    endfunction

    function automatic logic [SLICE_W-1:0] level_slice(input int lvl);
        int prod;
        prod = (LEVEL_COUNT - fix_lvl(lvl)) * int'(base_reg);
        return SLICE_W'(prod);
    endfunction

    task automatic sched_reset();
        base_reg = BASE_W'(BASE_RESET);
        for (int l = 0; l < LEVEL_COUNT; l++) begin
            ring_head[l] = 0;
            ring_tail[l] = 0;
            ring_len[l]  = 0;
        end
        for (int s = 0; s < TASK_SLOTS; s++) begin
            slot_state[s] = TS_ZOMBIE;
            slot_lvl[s]   = 0;
            slot_home[s]  = 0;
            slot_slice[s] = '0;
        end
        slot_state[0] = TS_READY;
        slot_lvl[0]   = LEVEL_COUNT - 1;
        slot_home[0]  = LEVEL_COUNT - 1;
        slot_slice[0] = SLICE_W'(IDLE_SLICE);
        run_valid  = 1'b0;
        run_slot   = 0;
        used_slots = 1;
    endtask

    task automatic ring_push(input int lvl, input int slot);
        int l;
        l = fix_lvl(lvl);
        if (ring_len[l] >= TASK_SLOTS) return;
        ring_slot[l][ring_tail[l]] = ID_W'(slot);
        ring_tail[l] = (ring_tail[l] + 1) % TASK_SLOTS;
        ring_len[l]++;
    endtask

    // Drops the first entry of the slot and closes the gap behind it.
    task automatic ring_drop(input int lvl, input int slot);
        int l;
        int n;
        l = fix_lvl(lvl);
        n = ring_len[l];
        for (int i = 0; i < n; i++) begin
            if (int'(ring_slot[l][(ring_head[l] + i) % TASK_SLOTS]) == slot) begin
                for (int j = i; j + 1 < n; j++)
                    ring_slot[l][(ring_head[l] + j) % TASK_SLOTS] =
                        ring_slot[l][(ring_head[l] + j + 1) % TASK_SLOTS];
                ring_tail[l] = (ring_tail[l] + TASK_SLOTS - 1) % TASK_SLOTS;
                ring_len[l]--;
                return;
            end
        end
    endtask

    task automatic stop_if_running(input int slot);
        if (run_valid && run_slot == slot) run_valid = 1'b0;
    endtask

    // Applies one operation to the shadow state and returns its outcome.
    task automatic schedule_op(input t_op op, input int id, output t_outcome res);
        bit ok;
        int s;
        ok = id < used_slots;
        res.chosen = '0;
        res.status = RS_IGNORED;
        case (op)
            OP_CREATE: begin
                if (used_slots >= TASK_SLOTS) begin
                    res.status = RS_FULL;
                end else begin
                    s = used_slots;
                    slot_state[s] = TS_READY;
                    slot_lvl[s]   = CREATE_LEVEL;
                    slot_home[s]  = CREATE_LEVEL;
                    slot_slice[s] = level_slice(CREATE_LEVEL);
                    used_slots++;
                    ring_push(CREATE_LEVEL, s);
                    res.chosen = ID_W'(s);
                    res.status = RS_DONE;
                end
            end
            OP_TICK: begin
                if (run_valid && slot_state[run_slot] == TS_RUNNING) begin
                    s = run_slot;
                    res.status = RS_DONE;
                    if (slot_slice[s] != 0) slot_slice[s]--;
                    if (slot_slice[s] == 0) begin
                        if (slot_lvl[s] + 1 < LEVEL_COUNT) slot_lvl[s]++;
                        slot_state[s] = TS_READY;
                        ring_push(slot_lvl[s], s);
                        run_valid = 1'b0;
                    end
                end
            end
            OP_PICK: begin
                for (int l = 0; l < LEVEL_COUNT; l++) begin
                    if (ring_len[l] == 0) continue;
                    s = ring_slot[l][ring_head[l]];
                    ring_head[l] = (ring_head[l] + 1) % TASK_SLOTS;
                    ring_len[l]--;
                    if (slot_state[s] == TS_READY) begin
                        run_valid = 1'b1;
                        run_slot  = s;
                        slot_state[s] = TS_RUNNING;
                        if (slot_slice[s] == 0) slot_slice[s] = level_slice(slot_lvl[s]);
                        res.chosen = ID_W'(s);
                        res.status = RS_DONE;
                        break;
                    end
                end
                // The idle task is the fallback when no ring yields a ready task.
                if (res.status != RS_DONE && slot_state[0] == TS_READY) begin
                    slot_state[0] = TS_RUNNING;
                    run_valid = 1'b1;
                    run_slot  = 0;
                    res.status = RS_DONE;
                end
            end
            OP_BLOCK: begin
                if (ok) begin
                    slot_state[id] = TS_BLOCKED;
                    ring_drop(slot_lvl[id], id);
                    stop_if_running(id);
                    res.status = RS_DONE;
                end
            end
            OP_WAKE: begin
                if (ok && slot_state[id] == TS_BLOCKED) begin
                    slot_state[id] = TS_READY;
                    slot_lvl[id]   = fix_lvl(slot_home[id]);
                    slot_slice[id] = level_slice(slot_lvl[id]);
                    ring_push(slot_lvl[id], id);
                    res.status = RS_DONE;
                end
            end
            OP_BOOST: begin
                if (ok) begin
                    slot_home[id]  = slot_lvl[id];
                    slot_lvl[id]   = 0;
                    slot_slice[id] = level_slice(0);
                    ring_drop(slot_home[id], id);
                    slot_state[id] = TS_READY;
                    ring_push(0, id);
                    res.status = RS_DONE;
                end
            end
            OP_KILL: begin
                if (ok && slot_state[id] != TS_ZOMBIE) begin
                    ring_drop(slot_lvl[id], id);
                    slot_state[id] = TS_ZOMBIE;
                    stop_if_running(id);
                    res.status = RS_DONE;
                end
            end
            default: begin
                if (ok && slot_state[id] == TS_RUNNING) begin
                    slot_state[id] = TS_READY;
                    ring_push(slot_lvl[id], id);
                    stop_if_running(id);
                    res.status = RS_DONE;
                end
            end
        endcase
    endtask

    function automatic t_item op_item(input t_op op, input int id);
        t_item it;
        it.op = op;
        it.task_id = ID_W'(id);
        it.is_cfg = 1'b0;
        it.base = '0;
        return it;
    endfunction

    function automatic t_item cfg_item(input int base);
        t_item it;
        it.op = OP_CREATE;
        it.task_id = '0;
        it.is_cfg = 1'b1;
        it.base = BASE_W'(base);
        return it;
    endfunction

    // Picks a task id biased toward slots in use, with some out-of-range noise.
    function automatic int pick_id(input int hint_used);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, TASK_SLOTS - 1);
        return $urandom_range(0, (hint_used > 1) ? hint_used - 1 : 1);
    endfunction

    // Stimulus: directed operations, then random phases each opened by a config
    // write. The slot count only grows, so a few phases reach the full table.
    initial begin
        int guess_used;
        int r;
        t_op op;
        int bases [6];
        bases = '{1, 1000, 1023, 0, 3, 10};
        pending_ops.push_back(op_item(OP_PICK, 0));
        pending_ops.push_back(op_item(OP_TICK, 0));
        pending_ops.push_back(op_item(OP_REQUEUE, 0));
        pending_ops.push_back(op_item(OP_BLOCK, 63));
        pending_ops.push_back(op_item(OP_CREATE, 0));
        pending_ops.push_back(op_item(OP_CREATE, 0));
        pending_ops.push_back(op_item(OP_PICK, 0));
        pending_ops.push_back(op_item(OP_TICK, 0));
        pending_ops.push_back(op_item(OP_REQUEUE, 1));
        pending_ops.push_back(op_item(OP_BOOST, 2));
        pending_ops.push_back(op_item(OP_BLOCK, 1));
        pending_ops.push_back(op_item(OP_WAKE, 1));
        pending_ops.push_back(op_item(OP_WAKE, 2));
        pending_ops.push_back(op_item(OP_KILL, 2));
        pending_ops.push_back(op_item(OP_KILL, 2));
        pending_ops.push_back(op_item(OP_BLOCK, 0));
        pending_ops.push_back(op_item(OP_PICK, 0));
        pending_ops.push_back(op_item(OP_PICK, 0));
        pending_ops.push_back(op_item(OP_PICK, 0));
        pending_ops.push_back(op_item(OP_WAKE, 0));
        pending_ops.push_back(op_item(OP_BOOST, 0));
        pending_ops.push_back(op_item(OP_PICK, 0));
        guess_used = 3;
        for (int ph = 0; ph < 6; ph++) begin
            pending_ops.push_back(cfg_item(bases[ph]));
            for (int k = 0; k < 270; k++) begin
                r = $urandom_range(0, 99);
                // Ticks dominate so that slices actually run out at small bases.
                if (r < 8 && guess_used < TASK_SLOTS + 2) op = OP_CREATE;
                else if (r < 45) op = OP_TICK;
                else if (r < 62) op = OP_PICK;
                else if (r < 70) op = OP_BLOCK;
                else if (r < 80) op = OP_WAKE;
                else if (r < 86) op = OP_BOOST;
                else if (r < 91) op = OP_KILL;
                else op = OP_REQUEUE;
                if (op == OP_CREATE) guess_used++;
                pending_ops.push_back(op_item(op, pick_id(guess_used)));
            end
        end
        // Fill the table to its limit and beyond, then pick once more.
        for (int k = 0; k < TASK_SLOTS + 2; k++) pending_ops.push_back(op_item(OP_CREATE, 0));
        pending_ops.push_back(op_item(OP_PICK, 0));
    end

    // Driver: bursts of random length separated by random gaps. A config write
    // waits until every outstanding result has come back and a pause elapsed.
    // A transaction stays on the channel until the monitor has seen it taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            task_ch.valid <= 1'b0;
            cfg_ch.valid  <= 1'b0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                cfg_ch.valid <= 1'b0;
            end else if (task_ch.valid && !task_taken) begin
                // Hold the transaction until it is taken.
            end else if (cfg_ch.valid) begin
            end else if (pending_ops.size() != 0 && pending_ops[0].is_cfg) begin
                task_ch.valid <= 1'b0;
                if (expected_results.size() == 0) begin
                    if (!phase_fence) begin
                        phase_fence = 1'b1;
                        repeat (200) @(posedge i_clk);
                    end else begin
                        cfg_ch.slice_base <= pending_ops[0].base;
                        cfg_ch.valid <= 1'b1;
                        phase_fence = 1'b0;
                    end
                end
            end else if (gap_left > 0) begin
                task_ch.valid <= 1'b0;
                gap_left--;
            end else if (pending_ops.size() != 0) begin
                task_ch.op      <= pending_ops[0].op;
                task_ch.task_id <= pending_ops[0].task_id;
                task_ch.valid   <= 1'b1;
                task_taken = 1'b0;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
                end
            end else begin
                task_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver stalls alternate between a steady-ready stretch and a choppy one.
    always @(negedge i_clk) begin
        if (stall_cnt == 0) begin
            stall_mode = ~stall_mode;
            stall_cnt = $urandom_range(20, 200);
        end
        stall_cnt--;
        result_ch.ready <= stall_mode ? 1'b1 : ($urandom_range(0, 3) == 0);
    end

    // Monitor: predicts on every accepted operation and checks every result.
    always @(posedge i_clk) begin
        t_outcome predicted;
        t_outcome oldest;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                base_reg = cfg_ch.slice_base;
                cfg_writes++;
                void'(pending_ops.pop_front());
            end
            if (task_ch.valid && task_ch.ready) begin
                schedule_op(t_op'(task_ch.op), int'(task_ch.task_id), predicted);
                expected_results.push_back(predicted);
                void'(pending_ops.pop_front());
                task_taken = 1'b1;
            end
            if (result_ch.valid && result_ch.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result chosen=%0d status=%0d",
                                 result_ch.chosen_task, result_ch.status);
                end else begin
                    oldest = expected_results.pop_front();
                    if (result_ch.chosen_task !== oldest.chosen ||
                        result_ch.status !== oldest.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d expected chosen=%0d status=%0d, got chosen=%0d status=%0d",
                                     results_seen, oldest.chosen, oldest.status,
                                     result_ch.chosen_task, result_ch.status);
                    end
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        results_seen = 0;
        cfg_writes = 0;
        phase_fence = 1'b0;
        task_taken = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_cnt = 0;
        stall_mode = 1'b0;
        task_ch.valid = 1'b0;
        task_ch.op = OP_CREATE;
        task_ch.task_id = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.slice_base = '0;
        result_ch.ready = 1'b0;
        sched_reset();
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (pending_ops.size() == 0 && expected_results.size() == 0);
        repeat (300) @(posedge i_clk);
        $display("Checked %0d scheduler results across %0d slice_base settings.",
                 results_seen, cfg_writes);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d operations and %0d results outstanding",
                 pending_ops.size(), expected_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
src/mlfq_pkg.sv
src/mlfq_if.sv
src/mlfq_dpath.sv
src/mlfq_ctrl.sv
src/mlfq_task_scheduler_top.sv
verif/mlfq_task_scheduler_top_tb.sv
